>>> rtl/bcba_pkg.sv
// Shared types and constants for the bitmap contiguous block allocator.
package bcba_pkg;

  // Field widths fixed by the request/response format
  localparam int BLK_W   = 11;   // block counts and volume size
  localparam int START_W = 10;   // start of a run on the request side
  localparam int FB_W    = 10;   // start of a run on the response side
  localparam int POS_W   = 11;   // block positions and run ends (below 2048)

  // Map word and scan chunk geometry
  localparam int WORD_W  = 64;
  localparam int BIT_W   = 6;                  // bit index within a map word
  localparam int WIDX_W  = POS_W - BIT_W;      // map word index
  localparam int CHUNK_W = 32;                 // blocks examined per scan cycle
  localparam int OFF_W   = 5;                  // offset within a chunk
  localparam int CHK_W   = BIT_W - OFF_W;      // chunk index within a word
  localparam int NCHUNK  = WORD_W / CHUNK_W;
  localparam int RUN_W   = BLK_W + 1;          // free run length

  localparam logic [BLK_W-1:0] TOTAL_RST = BLK_W'(1024);

  // Register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_TOTAL_BLOCKS = 1'b0;    // paddr[2] of total_blocks

  // Request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  // What one scan cycle reports about a chunk of the map
  typedef struct packed {
    logic             hit;
    logic [OFF_W-1:0] off;
    logic [RUN_W-1:0] run;
  } scan_res_t;

endpackage

>>> rtl/bcba_if.sv
// Request and response channel interfaces of the allocator.
interface bcba_req_if import bcba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [BLK_W-1:0]   block_count;
  logic [START_W-1:0] start_block;

  modport source (output valid, output mode, output block_count, output start_block,
                  input ready);
  modport sink   (input valid, input mode, input block_count, input start_block,
                  output ready);
endinterface

interface bcba_rsp_if import bcba_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [FB_W-1:0] first_block;

  modport source (output valid, output status, output first_block, input ready);
  modport sink   (input valid, input status, input first_block, output ready);
endinterface

>>> rtl/bitmap_contiguous_block_allocator.sv
// Bitmap first-fit contiguous block allocator: top level with request sequencer.
//
// Keeps one used bit per block in a RAM of 64-bit words and serves one request
// at a time. An allocate reads map words from block 0 and examines 32 blocks
// per cycle in S_SCAN, pausing in S_SCAN_RD to read each new word, up to the
// hit, then marks the run word by word (read, then write back) and responds.
// A free reads and writes back each word it spans. Out-of-range frees and
// failing zero-count or oversized allocates answer without touching the map.
// After reset the first RESERVED_BLOCKS blocks (at most 64) read as used; no
// clearing pass is needed and requests are taken at once. A new request is
// taken while the previous response still waits on its channel.
module bitmap_contiguous_block_allocator import bcba_pkg::*; #(
  parameter int MAX_BLOCKS      = 1024,
  parameter int RESERVED_BLOCKS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bcba_req_if.sink           req,
  bcba_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Volume sizes above 2047 cannot be expressed, so deeper maps stay unused.
  localparam int Words   = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int MaxWds  = 2 ** WIDX_W;
  localparam int Depth   = (Words > MaxWds) ? MaxWds : Words;
  localparam int Waw     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int MaxPos  = 2 ** POS_W - 1;
  localparam logic [BLK_W-1:0] MaxClip =
    BLK_W'((MAX_BLOCKS > MaxPos) ? MaxPos : MAX_BLOCKS);
  localparam logic [WORD_W-1:0] RsvMask =
    (RESERVED_BLOCKS >= WORD_W) ? {WORD_W{1'b1}}
                                : ((WORD_W'(1) << RESERVED_BLOCKS) - WORD_W'(1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_RESP
  } state_e;

  state_e              state_q;
  logic                mode_q;
  logic [BLK_W-1:0]    count_q;
  logic [POS_W-1:0]    lo_q;
  logic [POS_W-1:0]    hi_q;
  logic [WIDX_W-1:0]   w_q;
  logic [CHK_W-1:0]    chunk_q;
  logic [RUN_W-1:0]    run_q;
  status_e             res_status_q;
  logic [Depth-1:0]    vld_q;
  logic                rsp_valid_q;
  status_e             rsp_status_q;
  logic [FB_W-1:0]     rsp_first_q;

  logic [BLK_W-1:0]    total_blocks;
  logic [BLK_W-1:0]    eff_total;
  logic [Waw-1:0]      widx;
  logic                ram_re;
  logic                ram_we;
  logic [WORD_W-1:0]   ram_rdata;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WORD_W-1:0]   word_cur;
  logic [WORD_W-1:0]   mark_mask;
  logic [CHUNK_W-1:0]  chunk_bits;
  logic [POS_W-1:0]    base;
  logic [POS_W-1:0]    remain;
  logic [OFF_W:0]      limit;
  logic                scan_last;
  logic [POS_W-1:0]    hit_end;
  logic [POS_W-1:0]    hit_lo;
  logic [POS_W-1:0]    hi_m1;
  logic [BLK_W:0]      free_end;
  scan_res_t           scan_res;

  bcba_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .total_blocks_o (total_blocks)
  );

  bcba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (Depth)
  ) u_map (
    .clk_i   (clk_i),
    .re_i    (ram_re),
    .we_i    (ram_we),
    .addr_i  (widx),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  bcba_scan u_scan (
    .bits_i  (chunk_bits),
    .run_i   (run_q),
    .count_i (count_q),
    .limit_i (limit),
    .res_o   (scan_res)
  );

  assign eff_total = (total_blocks > MaxClip) ? MaxClip : total_blocks;
  assign widx      = w_q[Waw-1:0];
  assign ram_re    = (state_q == S_SCAN_RD) || (state_q == S_MARK_RD);
  assign ram_we    = (state_q == S_MARK_WR);

  // Words never written read as their reset contents.
  assign word_cur = vld_q[widx] ? ram_rdata
                                : ((widx == '0) ? RsvMask : '0);

  assign chunk_bits = word_cur[int'(chunk_q) * CHUNK_W +: CHUNK_W];
  assign base       = {w_q, chunk_q, {OFF_W{1'b0}}};
  assign remain     = POS_W'(eff_total) - base;
  assign scan_last  = (remain <= POS_W'(CHUNK_W));
  assign limit      = scan_last ? remain[OFF_W:0] : (OFF_W + 1)'(CHUNK_W);
  assign hit_end    = base + POS_W'(scan_res.off) + POS_W'(1);
  assign hit_lo     = hit_end - POS_W'(count_q);
  assign hi_m1      = hi_q - POS_W'(1);
  assign free_end   = {1'b0, BLK_W'(req.start_block)} + {1'b0, req.block_count};

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      mark_mask[b] = ({w_q, BIT_W'(b)} >= lo_q) && ({w_q, BIT_W'(b)} < hi_q);
    end
    ram_wdata = (mode_q == MODE_ALLOC) ? (word_cur | mark_mask) : (word_cur & ~mark_mask);
  end

  assign req.ready       = (state_q == S_IDLE);
  assign rsp.valid       = rsp_valid_q;
  assign rsp.status      = rsp_status_q;
  assign rsp.first_block = rsp_first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MODE_ALLOC;
      count_q      <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      w_q          <= '0;
      chunk_q      <= '0;
      run_q        <= '0;
      res_status_q <= ST_OK;
      vld_q        <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= ST_OK;
      rsp_first_q  <= '0;
    end else begin
      // S_RESP handles the response register itself
      if (rsp.ready && (state_q != S_RESP)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            mode_q  <= req.mode;
            count_q <= req.block_count;
            if (req.mode == MODE_ALLOC) begin
              if ((req.block_count == '0) || (req.block_count > eff_total)) begin
                res_status_q <= ST_NOSPACE;
                state_q      <= S_RESP;
              end else begin
                w_q          <= '0;
                chunk_q      <= '0;
                run_q        <= '0;
                res_status_q <= ST_NOSPACE;
                state_q      <= S_SCAN_RD;
              end
            end else if (free_end > {1'b0, eff_total}) begin
              res_status_q <= ST_RANGE;
              state_q      <= S_RESP;
            end else begin
              res_status_q <= ST_OK;
              lo_q         <= POS_W'(req.start_block);
              hi_q         <= free_end[POS_W-1:0];
              w_q          <= WIDX_W'(req.start_block >> BIT_W);
              state_q      <= (req.block_count == '0) ? S_RESP : S_MARK_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_res.hit) begin
            lo_q         <= hit_lo;
            hi_q         <= hit_end;
            w_q          <= hit_lo[POS_W-1:BIT_W];
            res_status_q <= ST_OK;
            state_q      <= S_MARK_RD;
          end else if (scan_last) begin
            state_q <= S_RESP;
          end else begin
            run_q   <= scan_res.run;
            chunk_q <= chunk_q + CHK_W'(1);
            if (chunk_q == CHK_W'(NCHUNK - 1)) begin
              w_q     <= w_q + WIDX_W'(1);
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_MARK_RD: begin
          state_q <= S_MARK_WR;
        end
        S_MARK_WR: begin
          // Write lands before the next read is issued, so no forwarding.
          vld_q[widx] <= 1'b1;
          if (w_q == hi_m1[POS_W-1:BIT_W]) begin
            state_q <= S_RESP;
          end else begin
            w_q     <= w_q + WIDX_W'(1);
            state_q <= S_MARK_RD;
          end
        end
        S_RESP: begin
          if (!rsp_valid_q || rsp.ready) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= res_status_q;
            rsp_first_q  <= ((res_status_q == ST_OK) && (mode_q == MODE_ALLOC))
                            ? lo_q[FB_W-1:0] : '0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/bcba_ram.sv
// Generic single-port synchronous RAM with registered read data.
module bcba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   re_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bcba_cfg.sv
// APB register block holding the volume size.
module bcba_cfg import bcba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [BLK_W-1:0]   total_blocks_o
);

  logic [BLK_W-1:0] total_q;
  logic             wr_en;

  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_TOTAL_BLOCKS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RST;
    end else if (wr_en) begin
      total_q <= pwdata[BLK_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOTAL_BLOCKS: prdata = PDATA_W'(total_q);
      default:          prdata = '0;
    endcase
  end

  assign pready         = 1'b1;
  assign total_blocks_o = total_q;

endmodule

>>> rtl/bcba_scan.sv
// First-fit evaluator for one chunk of the used map.
module bcba_scan import bcba_pkg::*; (
  input  logic [CHUNK_W-1:0] bits_i,    // used bits of the chunk
  input  logic [RUN_W-1:0]   run_i,     // free run carried into the chunk
  input  logic [BLK_W-1:0]   count_i,   // run length wanted
  input  logic [OFF_W:0]     limit_i,   // positions below the volume end
  output scan_res_t          res_o
);

  // Each position is judged on its own: run length ending there is either
  // the distance to the last used bit at or below it, or the carry-in plus
  // its position plus one when the chunk is free up to it.
  always_comb begin
    logic             found;
    logic [OFF_W-1:0] lu;
    logic [RUN_W-1:0] run_k;
    res_o = '0;
    for (int k = CHUNK_W - 1; k >= 0; k--) begin
      found = 1'b0;
      lu    = '0;
      for (int j = 0; j <= k; j++) begin
        if (bits_i[j]) begin
          found = 1'b1;
          lu    = OFF_W'(j);
        end
      end
      run_k = found ? RUN_W'(OFF_W'(k) - lu) : run_i + RUN_W'(k + 1);
      if (k == CHUNK_W - 1) begin
        res_o.run = run_k;
      end
      if (!bits_i[k] && (k < int'(limit_i)) && (run_k >= {1'b0, count_i})) begin
        res_o.hit = 1'b1;
        res_o.off = OFF_W'(k);
      end
    end
  end

endmodule

>>> rtl/bcba_checker.sv
// Port-level assertions for the allocator, bound to the top level.
module bcba_checker import bcba_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input logic [1:0]      rsp_status_i,
  input logic [FB_W-1:0] rsp_first_block_i
);

  logic       req_acc;
  logic       rsp_acc;
  logic [1:0] outst_q;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  // Requests taken whose response has not been delivered yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (req_acc && !rsp_acc) begin
      outst_q <= outst_q + 2'd1;
    end else if (!req_acc && rsp_acc) begin
      outst_q <= outst_q - 2'd1;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("request taken while previous one still in work");

  a_no_spurious_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (outst_q != 2'd0))
    else $error("response without an outstanding request");

  a_outst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q != 2'd3)
    else $error("more than two requests outstanding");

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i != ST_OK)) |-> (rsp_first_block_i == '0))
    else $error("failed request reports a nonzero first block");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_first_block_i)))
    else $error("stalled response changed");

endmodule

bind bitmap_contiguous_block_allocator bcba_checker u_bcba_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req.valid),
  .req_ready_i       (req.ready),
  .rsp_valid_i       (rsp.valid),
  .rsp_ready_i       (rsp.ready),
  .rsp_status_i      (rsp.status),
  .rsp_first_block_i (rsp.first_block)
);

>>> bench/bitmap_contiguous_block_allocator_tb.sv
// Self-checking testbench: allocate and free requests against a bitmap predictor.
`timescale 1ns / 100ps

module bitmap_contiguous_block_allocator_tb;
  import bcba_pkg::*;

  localparam int MAX_BLK = 1024;
  localparam int RSV_BLK = 6;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [PADDR_W-1:0] VOLUME_ADDR = {REG_TOTAL_BLOCKS, 2'b00};

  typedef struct packed {
    status_e         status;
    logic [FB_W-1:0] first_block;
  } reply_t;

  typedef struct {
    int at;
    int len;
  } run_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} stall_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;

  bcba_req_if req_ch ();
  bcba_rsp_if rsp_ch ();

  bitmap_contiguous_block_allocator #(
    .MAX_BLOCKS(MAX_BLK),
    .RESERVED_BLOCKS(RSV_BLK)
  ) dut (
    .clk_i, .rst_ni, .req(req_ch), .rsp(rsp_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [MAX_BLK-1:0] used_blocks;
  logic [BLK_W-1:0]   volume_reg;
  reply_t             reply_q[$];
  reply_t             last_reply;
  run_t               live_runs[$];
  int                 mismatch_cnt = 0;
  int                 tx_burst_left = 0;

  // receiver stall control
  stall_e rx_style = RX_OPEN;
  int     rx_span = 0;
  int     rx_tick = 0;
  int     rx_hold_len = 0;
  int     rx_hold_left = 0;

  function automatic reply_t serve_request(input logic mode, input logic [BLK_W-1:0] cnt,
                                           input logic [START_W-1:0] first);
    int lim, n, run, run_at, k;
    bit found;
    reply_t r;
    lim = (int'(volume_reg) > MAX_BLK) ? MAX_BLK : int'(volume_reg);
    n = int'(cnt);
    r.status = ST_NOSPACE;
    r.first_block = '0;
    found = 1'b0;
    if (mode == MODE_ALLOC) begin
      if (n != 0 && n <= lim) begin
        run = 0;
        run_at = 0;
        // run restarts at every used block
        for (k = 0; k < lim && !found; k++) begin
          if (used_blocks[k]) begin
            run = 0;
          end else begin
            if (run == 0) run_at = k;
            run++;
            if (run == n) found = 1'b1;
          end
        end
        if (found) begin
          for (k = run_at; k < run_at + n; k++) used_blocks[k] = 1'b1;
          r.status = ST_OK;
          r.first_block = FB_W'(run_at);
        end
      end
    end else if (int'(first) + n > lim) begin
      r.status = ST_RANGE;
    end else begin
      for (k = int'(first); k < int'(first) + n; k++) used_blocks[k] = 1'b0;
      r.status = ST_OK;
    end
    return r;
  endfunction

  // Offers one request in bursts with random gaps; predicts it on acceptance.
  task automatic issue_request(input logic mode, input logic [BLK_W-1:0] cnt,
                               input logic [START_W-1:0] first);
    int gap;
    if (tx_burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 60);
      tx_burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    tx_burst_left--;
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= mode;
    req_ch.block_count <= cnt;
    req_ch.start_block <= first;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    last_reply = serve_request(mode, cnt, first);
    reply_q.push_back(last_reply);
  endtask

  task automatic drain_replies(input bit settle);
    req_ch.valid <= 1'b0;
    tx_burst_left = 0;
    while (reply_q.size() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write, then read back; block must be idle
  task automatic set_volume(input logic [BLK_W-1:0] v);
    drain_replies(1'b1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VOLUME_ADDR;
    pwdata  <= PDATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    volume_reg = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata != PDATA_W'(v)) begin
      $error("total_blocks readback: expected %0d, got %0d", v, prdata);
      mismatch_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed_requests();
    issue_request(MODE_ALLOC, 0, 0);              // zero count fails
    issue_request(MODE_ALLOC, 1, 10'h3FF);
    issue_request(MODE_ALLOC, 10, 0);
    issue_request(MODE_FREE, RSV_BLK, 0);         // reserved blocks can be freed
    issue_request(MODE_ALLOC, 3, 0);
    issue_request(MODE_ALLOC, 4, 0);              // gap of 3 too short, must skip
    issue_request(MODE_FREE, 1, 10'd1023);        // already free
    issue_request(MODE_FREE, 2, 10'd1023);        // runs past the volume
    issue_request(MODE_FREE, 0, 0);
    issue_request(MODE_ALLOC, MAX_BLK, 0);
    issue_request(MODE_FREE, MAX_BLK, 0);
    issue_request(MODE_ALLOC, MAX_BLK, 10'h155);
  endtask

  task automatic test_volume_extremes();
    set_volume(0);
    issue_request(MODE_ALLOC, 5, 0);
    issue_request(MODE_FREE, 0, 0);
    issue_request(MODE_FREE, 1, 0);
    issue_request(MODE_FREE, 0, 1);
    set_volume(BLK_W'(2047));                     // clamps to the map size
    issue_request(MODE_FREE, MAX_BLK, 0);
    issue_request(MODE_ALLOC, MAX_BLK, 0);
    issue_request(MODE_FREE, MAX_BLK, 1);
    set_volume(1);
    issue_request(MODE_FREE, 1, 0);
    issue_request(MODE_ALLOC, 1, 0);
    issue_request(MODE_ALLOC, 1, 0);
    // blocks beyond a shrunk volume keep their bits
    set_volume(MAX_BLK);
    issue_request(MODE_FREE, MAX_BLK, 0);
    issue_request(MODE_ALLOC, 200, 0);
    issue_request(MODE_FREE, 150, 0);
    set_volume(160);
    issue_request(MODE_ALLOC, 155, 0);
    set_volume(MAX_BLK);
    issue_request(MODE_ALLOC, 155, 0);
  endtask

  task automatic test_random_traffic(input logic [BLK_W-1:0] vol, input int n_items);
    int n, pick, sz, idx, off, cnt, first;
    run_t r;
    set_volume(vol);
    for (n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 || (pick < 80 && live_runs.size() == 0)) begin
        sz = $urandom_range(0, 99);
        cnt = (sz < 70) ? $urandom_range(1, 16) :
              (sz < 90) ? $urandom_range(17, 64) :
              (sz < 98) ? $urandom_range(65, 300) : $urandom_range(301, MAX_BLK);
        issue_request(MODE_ALLOC, BLK_W'(cnt), START_W'($urandom_range(0, 1023)));
        if (last_reply.status == ST_OK) begin
          r.at = int'(last_reply.first_block);
          r.len = cnt;
          live_runs.push_back(r);
        end
      end else if (pick < 80) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        r = live_runs[idx];
        live_runs.delete(idx);
        first = r.at;
        cnt = r.len;
        if ($urandom_range(0, 4) == 0) begin
          off = $urandom_range(0, r.len - 1);
          first = r.at + off;
          cnt = $urandom_range(0, r.len - off);
        end
        issue_request(MODE_FREE, BLK_W'(cnt), START_W'(first));
      end else if (pick < 90) begin
        issue_request(MODE_FREE, BLK_W'($urandom_range(0, 8)),
                      START_W'($urandom_range(0, 1023)));
      end else begin
        issue_request(logic'($urandom_range(0, 1)), BLK_W'($urandom_range(0, MAX_BLK)),
                      START_W'($urandom_range(0, 1023)));
      end
      if ($urandom_range(0, 49) == 0) drain_replies(1'b0);
    end
  endtask

  // long receiver hold-off while requests keep coming: input side must stall
  task automatic test_output_stall();
    int n, idx;
    run_t r;
    drain_replies(1'b0);
    @(posedge clk_i);
    rx_hold_len = 300;
    tx_burst_left = 24;
    for (n = 0; n < 20; n++) begin
      if (n % 3 == 2 && live_runs.size() != 0) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        r = live_runs[idx];
        live_runs.delete(idx);
        issue_request(MODE_FREE, BLK_W'(r.len), START_W'(r.at));
      end else begin
        issue_request(MODE_ALLOC, BLK_W'($urandom_range(1, 4)), START_W'($urandom_range(0, 1023)));
        if (last_reply.status == ST_OK) begin
          r.at = int'(last_reply.first_block);
          r.len = int'(req_ch.block_count);
          live_runs.push_back(r);
        end
      end
    end
    drain_replies(1'b1);
  endtask

  always @(posedge clk_i) begin : rsp_stall
    if (rx_hold_len != 0) begin
      rx_hold_left = rx_hold_len;
      rx_hold_len = 0;
    end
    if (rx_span == 0) begin
      rx_style = stall_e'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 150);
    end else begin
      rx_span--;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      case (rx_style)
        RX_OPEN:   rsp_ch.ready <= 1'b1;
        RX_COIN:   rsp_ch.ready <= logic'($urandom_range(0, 1));
        RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   rsp_ch.ready <= (rx_tick % 4 != 3);
      endcase
    end
    rx_tick++;
  end

  always @(posedge clk_i) begin : rsp_check
    reply_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (reply_q.size() == 0) begin
        $error("unexpected transaction: status %0d, first_block %0d",
               rsp_ch.status, rsp_ch.first_block);
        mismatch_cnt++;
      end else begin
        want = reply_q.pop_front();
        if (rsp_ch.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatch_cnt++;
        end
        if (rsp_ch.first_block != want.first_block) begin
          $error("first_block: expected %0d, got %0d", want.first_block,
                 rsp_ch.first_block);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_ALLOC;
    req_ch.block_count = '0;
    req_ch.start_block = '0;
    rsp_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    used_blocks = '0;
    used_blocks[RSV_BLK-1:0] = '1;
    volume_reg = TOTAL_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_requests();
    test_volume_extremes();
    test_random_traffic(MAX_BLK, 90);
    test_output_stall();
    test_random_traffic(BLK_W'($urandom_range(200, 1000)), 80);
    test_random_traffic(64, 60);
    test_random_traffic(BLK_W'(2047), 80);
    test_random_traffic(1, 15);
    test_random_traffic(BLK_W'($urandom_range(1, MAX_BLK)), 70);
    drain_replies(1'b1);

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
